// ----- rtl/gyro_calibrate_and_smooth_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gyro calibrate-and-smooth core
// Clocked property checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GYRO_CALIBRATE_AND_SMOOTH_CORE_MACROS_SVH
`define GYRO_CALIBRATE_AND_SMOOTH_CORE_MACROS_SVH

`ifndef SYNTH
// Check a property on the rising clock edge, off while reset is asserted
`define GCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on the rising clock edge, also during reset
`define GCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/gcs_pkg.sv -----
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types, codes and defaults for the gyro calibrate-and-smooth core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

  // Fixed field widths
  localparam int WORD_W   = 16;
  localparam int CMD_W    = 2;
  localparam int BAND_W   = 7;
  localparam int NEED_W   = 8;
  localparam int SKIP_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int NUM_AXES = 3;

  // Parameter defaults
  localparam int AVG_SHIFT_DEF = 8;
  localparam int FRAC_BITS_DEF = 8;

  // Command codes (code 3 behaves as a plain sample)
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_BAND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_NEEDED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT   = 2'd2;

  // Configuration reset values
  localparam logic [BAND_W-1:0] QUIET_BAND_RST   = 7'd5;
  localparam logic [NEED_W-1:0] QUIET_NEEDED_RST = 8'd30;
  localparam logic [SKIP_W-1:0] SKIP_COUNT_RST   = 10'd100;

  // Calibration phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SETTLE = 3'b010,
    PH_SUM    = 3'b100
  } phase_t;

  // Per-word control from the merge stage to every axis lane
  typedef struct packed {
    logic upd;      // word accepted this cycle
    logic start;    // calibration start: clear offset and last filtered value
    logic load;     // load offset from the word
    logic sum_clr;  // clear the running sum
    logic sum_en;   // add this filtered value to the sum
    logic commit;   // write averaged sum as the new offset
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/gcs_lane.sv -----
// ----------------------------------------------------------------------------
// gcs_lane
// One axis: offset removal, first-order low-pass, quiet test and bias sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcs_lane #(
  parameter int AVG_SHIFT = gcs_pkg::AVG_SHIFT_DEF,
  parameter int FRAC_BITS = gcs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gcs_pkg::lane_ctrl_t               ctrl,
  input  wire logic signed [gcs_pkg::WORD_W-1:0] word,
  input  wire logic        [gcs_pkg::BAND_W-1:0] quiet_band,
  output logic signed      [gcs_pkg::WORD_W-1:0] filt,
  output logic                                   quiet
);
  import gcs_pkg::*;

  localparam int ACC_W = WORD_W + FRAC_BITS;
  localparam int EXT_W = ACC_W + 2;
  localparam int SUM_W = WORD_W + AVG_SHIFT;
  localparam int DIF_W = WORD_W + 1;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [WORD_W-1:0] prev_r, prev_nxt;
  logic signed [WORD_W-1:0] ofs_r, ofs_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;

  logic signed [WORD_W-1:0] ofs_eff;
  logic signed [WORD_W-1:0] x;
  logic signed [EXT_W-1:0]  acc_ext;
  logic signed [EXT_W-1:0]  mix;
  logic signed [ACC_W-1:0]  acc_upd;
  logic signed [ACC_W-1:0]  trunc_src;
  logic signed [ACC_W-1:0]  trunc_bias;
  logic signed [WORD_W-1:0] prev_eff;
  logic signed [DIF_W-1:0]  diff;
  logic signed [DIF_W-1:0]  band;
  logic signed [SUM_W-1:0]  sum_base;
  logic signed [SUM_W-1:0]  sum_add;
  logic signed [WORD_W-1:0] ofs_avg;

  // Remove offset, wrapping to word width; a start runs with a cleared offset
  assign ofs_eff = ctrl.start ? '0 : ofs_r;
  assign x       = word - ofs_eff;

  // y = floor((3*y + x*2^F) / 4)
  assign acc_ext = EXT_W'(acc_r);
  assign mix     = (acc_ext <<< 1) + acc_ext + (EXT_W'(x) <<< FRAC_BITS);
  assign acc_upd = ACC_W'(mix >>> 2);

  // Truncate toward zero; a load repeats the held filter value
  assign trunc_src  = ctrl.load ? acc_r : acc_upd;
  assign trunc_bias = {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{trunc_src[ACC_W-1]}}};
  assign filt       = WORD_W'((trunc_src + trunc_bias) >>> FRAC_BITS);

  // Quiet when the exact change from the last filtered value is within the band
  assign prev_eff = ctrl.start ? '0 : prev_r;
  assign diff     = DIF_W'(filt) - DIF_W'(prev_eff);
  assign band     = DIF_W'({1'b0, quiet_band});
  assign quiet    = !((diff > band) || (diff < -band));

  // Accumulate the bias sum and average it on commit
  assign sum_base = ctrl.sum_clr ? '0 : sum_r;
  assign sum_add  = sum_base + (ctrl.sum_en ? SUM_W'(filt) : '0);
  assign ofs_avg  = WORD_W'(sum_add >>> AVG_SHIFT);

  // Next state
  always_comb begin
    acc_nxt  = acc_r;
    prev_nxt = prev_r;
    ofs_nxt  = ofs_r;
    sum_nxt  = sum_r;
    if (ctrl.upd) begin
      if (ctrl.load) begin
        ofs_nxt = word;
      end else begin
        acc_nxt  = acc_upd;
        prev_nxt = filt;
        sum_nxt  = sum_add;
        if (ctrl.commit) begin
          ofs_nxt = ofs_avg;
        end else begin
          ofs_nxt = ofs_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
      ofs_r  <= '0;
      sum_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      prev_r <= prev_nxt;
      ofs_r  <= ofs_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// gcs_ctrl
// Merge stage: combines lane quiet flags and sequences settle and sum phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_calibrate_and_smooth_core_macros.svh"

module gcs_ctrl #(
  parameter int AVG_SHIFT = gcs_pkg::AVG_SHIFT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_fire,
  input  wire logic [gcs_pkg::CMD_W-1:0]            cmd,
  input  wire logic [gcs_pkg::NUM_AXES-1:0]         lane_quiet,
  input  wire logic [gcs_pkg::NEED_W-1:0]           quiet_needed,
  input  wire logic [gcs_pkg::SKIP_W-1:0]           skip_count,
  output gcs_pkg::lane_ctrl_t                       ctrl,
  output logic                                      calibrating,
  output logic                                      done
);
  import gcs_pkg::*;

  localparam int SCNT_W = ((SKIP_W > AVG_SHIFT) ? SKIP_W : AVG_SHIFT) + 1;

  phase_t              phase_r, phase_nxt, phase_cur;
  logic [NEED_W-1:0]   qcnt_r, qcnt_nxt, qcnt_cur, qcnt_inc;
  logic [SCNT_W-1:0]   scnt_r, scnt_nxt, scnt_cur, scnt_inc;
  logic [NEED_W-1:0]   need;
  logic [SCNT_W-1:0]   skip_ext;
  logic [SCNT_W-1:0]   total;
  logic                is_start;
  logic                is_load;
  logic                all_quiet;
  logic                enter_sum;

  assign is_start  = (cmd == CMD_START);
  assign is_load   = (cmd == CMD_LOAD);
  assign all_quiet = &lane_quiet;
  assign need      = (quiet_needed == '0) ? NEED_W'(1) : quiet_needed;
  assign skip_ext  = SCNT_W'(skip_count);
  assign total     = skip_ext + (SCNT_W'(1) << AVG_SHIFT);

  // A start restarts the sequence and handles this word as the first settle sample
  assign phase_cur = is_start ? PH_SETTLE : phase_r;
  assign qcnt_cur  = is_start ? '0 : qcnt_r;
  assign scnt_cur  = is_start ? '0 : scnt_r;
  assign qcnt_inc  = qcnt_cur + NEED_W'(1);
  assign scnt_inc  = scnt_cur + SCNT_W'(1);

  // Decide the outcome of the word at the input
  always_comb begin
    phase_nxt    = phase_r;
    qcnt_nxt     = qcnt_r;
    scnt_nxt     = scnt_r;
    ctrl.upd     = in_fire;
    ctrl.start   = in_fire && is_start;
    ctrl.load    = in_fire && is_load;
    ctrl.sum_clr = 1'b0;
    ctrl.sum_en  = 1'b0;
    ctrl.commit  = 1'b0;
    calibrating  = 1'b0;
    done         = 1'b0;
    enter_sum    = 1'b0;
    if (is_load) begin
      phase_nxt = PH_IDLE;
    end else begin
      phase_nxt    = phase_cur;
      qcnt_nxt     = qcnt_cur;
      scnt_nxt     = scnt_cur;
      ctrl.sum_clr = is_start;
      unique case (phase_cur)
        PH_SETTLE: begin
          calibrating = 1'b1;
          if (all_quiet) begin
            qcnt_nxt = qcnt_inc;
            if (qcnt_inc >= need) begin
              enter_sum    = 1'b1;
              phase_nxt    = PH_SUM;
              scnt_nxt     = '0;
              ctrl.sum_clr = 1'b1;
            end
          end
        end
        PH_SUM: begin
          calibrating = 1'b1;
          ctrl.sum_en = (scnt_cur >= skip_ext);
          scnt_nxt    = scnt_inc;
          if (scnt_inc >= total) begin
            ctrl.commit = 1'b1;
            phase_nxt   = PH_IDLE;
            calibrating = 1'b0;
            done        = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_cur;
        end
      endcase
    end
  end

  // Advance only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      qcnt_r  <= '0;
      scnt_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      qcnt_r  <= qcnt_nxt;
      scnt_r  <= scnt_nxt;
    end
  end

  `GCS_ASSERT(a_commit_in_sum, clk, rst_n, ctrl.commit |-> phase_r == PH_SUM, "early commit")
  `GCS_ASSERT(a_load_idles, clk, rst_n, ctrl.load |=> phase_r == PH_IDLE, "load not idle")
  `GCS_ASSERT(a_sum_ph, clk, rst_n, in_fire && enter_sum |=> phase_r == PH_SUM, "no sum phase")
  `GCS_ASSERT(a_sum_cnt, clk, rst_n, in_fire && enter_sum |=> scnt_r == '0, "stale count")

endmodule

`default_nettype wire

// ----- rtl/gyro_calibrate_and_smooth_core.sv -----
// ----------------------------------------------------------------------------
// gyro_calibrate_and_smooth_core
// Three-axis gyro offset removal, low-pass smoothing and bias calibration.
// ----------------------------------------------------------------------------
// Takes one three-axis gyro word per clock while in_stall is low and returns
// one filtered word for each axis in the cycle after acceptance, through an
// output register; with no stall downstream the block sustains one word per
// cycle. The rate is set by the per-axis filter update (offset subtract,
// 3*y + x add, truncation and quiet compare), which is combinational in each
// of three parallel lanes, and a merge stage that combines the lane quiet
// flags and runs the calibration sequence. in_stall rises only while a result
// waits at the output under out_stall. Configuration writes are always ready
// and must be issued only while the block holds no pending word.
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_calibrate_and_smooth_core_macros.svh"

module gyro_calibrate_and_smooth_core #(
  parameter int AVG_SHIFT = gcs_pkg::AVG_SHIFT_DEF,
  parameter int FRAC_BITS = gcs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic        [gcs_pkg::CMD_W-1:0]     in_command,
  input  wire logic signed [gcs_pkg::WORD_W-1:0]    in_gyro_x_word,
  input  wire logic signed [gcs_pkg::WORD_W-1:0]    in_gyro_y_word,
  input  wire logic signed [gcs_pkg::WORD_W-1:0]    in_gyro_z_word,
  // Result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [gcs_pkg::WORD_W-1:0]    out_filtered_x,
  output logic signed      [gcs_pkg::WORD_W-1:0]    out_filtered_y,
  output logic signed      [gcs_pkg::WORD_W-1:0]    out_filtered_z,
  output logic                                      out_calibrating,
  output logic                                      out_calibration_done,
  // Configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [gcs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import gcs_pkg::*;

  logic [BAND_W-1:0] quiet_band_r;
  logic [NEED_W-1:0] quiet_needed_r;
  logic [SKIP_W-1:0] skip_count_r;

  logic                     in_fire;
  lane_ctrl_t               ctrl;
  logic [NUM_AXES-1:0]      lane_quiet;
  logic signed [WORD_W-1:0] lane_word [NUM_AXES];
  logic signed [WORD_W-1:0] lane_filt [NUM_AXES];
  logic                     calibrating;
  logic                     done;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                     out_cal_r, out_done_r;

  // Accept whenever the output register is free or being drained
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_band_r   <= QUIET_BAND_RST;
      quiet_needed_r <= QUIET_NEEDED_RST;
      skip_count_r   <= SKIP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUIET_BAND:   quiet_band_r   <= cfg_data[BAND_W-1:0];
        CFG_QUIET_NEEDED: quiet_needed_r <= cfg_data[NEED_W-1:0];
        CFG_SKIP_COUNT:   skip_count_r   <= cfg_data[SKIP_W-1:0];
        default: begin
          quiet_band_r <= quiet_band_r;
        end
      endcase
    end
  end

  // Axis lanes
  assign lane_word[0] = in_gyro_x_word;
  assign lane_word[1] = in_gyro_y_word;
  assign lane_word[2] = in_gyro_z_word;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    gcs_lane #(
      .AVG_SHIFT (AVG_SHIFT),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .word       (lane_word[a]),
      .quiet_band (quiet_band_r),
      .filt       (lane_filt[a]),
      .quiet      (lane_quiet[a])
    );
  end

  // Merge lane results and sequence calibration
  gcs_ctrl #(
    .AVG_SHIFT (AVG_SHIFT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .cmd          (in_command),
    .lane_quiet   (lane_quiet),
    .quiet_needed (quiet_needed_r),
    .skip_count   (skip_count_r),
    .ctrl         (ctrl),
    .calibrating  (calibrating),
    .done         (done)
  );

  // Output register: load on accept, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_x_r    <= lane_filt[0];
      out_y_r    <= lane_filt[1];
      out_z_r    <= lane_filt[2];
      out_cal_r  <= calibrating;
      out_done_r <= done;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_filtered_x       = out_x_r;
  assign out_filtered_y       = out_y_r;
  assign out_filtered_z       = out_z_r;
  assign out_calibrating      = out_cal_r;
  assign out_calibration_done = out_done_r;

  `GCS_ASSERT(a_no_overwrite, clk, rst_n, out_valid_r && out_stall |-> !in_fire, "overwrite")
  `GCS_ASSERT(a_done_cal, clk, rst_n, out_valid_r |-> !(out_done_r && out_cal_r), "done with cal")
  `GCS_ASSERT(a_out_hold, clk, rst_n, out_valid_r && out_stall |=> out_valid_r, "word dropped")

endmodule

`default_nettype wire
